FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the interval union table rtl
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check with a fixed message
`define IUT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// concurrent check with a caller message
`define IUT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

FILE: hw/rtl/iut_pkg.sv
// shared constants, codes and command struct of the interval union table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iut_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int VALUE_BITS  = 48;
  localparam int ADDR_BITS   = $clog2(TABLE_SLOTS);
  localparam int CNT_BITS    = $clog2(TABLE_SLOTS + 1);
  localparam int COV_BITS    = VALUE_BITS + 1;
  localparam int TALLY_BITS  = 32;
  localparam int ENTRY_BITS  = 2 * VALUE_BITS;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic                 load;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 finish;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iut_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/iut_ctrl.sv
// sequencer of the interval union table: scan, finish and result strobe
// depends on iut_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iut_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  output logic             done_o,
  output iut_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_SETTLE,
    S_RESP
  } state_e;

  state_e                        state_q;
  logic [iut_pkg::ADDR_BITS-1:0] slot_q;
  logic                          busy_q;
  logic                          done_q;
  logic                          accept;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
            slot_q  <= '0;
            busy_q  <= 1'b1;
          end
        end
        S_SCAN: begin
          slot_q <= slot_q + iut_pkg::ADDR_BITS'(1);
          if (slot_q == iut_pkg::ADDR_BITS'(iut_pkg::TABLE_SLOTS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          state_q <= S_SETTLE;
        end
        S_SETTLE: begin
          state_q <= S_RESP;
          done_q  <= 1'b1;
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load    = accept;
    cmd_o.rd_en   = (state_q == S_SCAN);
    cmd_o.rd_addr = slot_q;
    cmd_o.finish  = (state_q == S_FINISH);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  `IUT_ASSERT(a_done_while_busy, done_q |-> busy_q)
  `IUT_ASSERT(a_done_one_cycle, done_q |=> !done_q)
  `IUT_ASSERT_MSG(a_load_sets_busy, accept |=> (busy_q && !done_q), "load did not raise busy")

endmodule

`default_nettype wire

FILE: hw/rtl/iut_dp.sv
// datapath of the interval union table: slot memory, merge, counters
// depends on iut_pkg, iut_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iut_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire iut_pkg::cmd_t                   cmd_i,
  input  wire logic                            opcode_i,
  input  wire logic [iut_pkg::VALUE_BITS-1:0]  low_value_i,
  input  wire logic [iut_pkg::VALUE_BITS-1:0]  high_value_i,
  output logic      [1:0]                      status_o,
  output logic                                 hit_o,
  output logic      [iut_pkg::COV_BITS-1:0]    covered_total_o,
  output logic      [iut_pkg::CNT_BITS-1:0]    slots_in_use_o,
  output logic      [iut_pkg::TALLY_BITS-1:0]  hits_so_far_o
);

  localparam int VB = iut_pkg::VALUE_BITS;
  localparam int AW = iut_pkg::ADDR_BITS;

  // item registers
  logic          op_q;
  logic          bad_q;
  logic [VB-1:0] lo_q, hi_q, mlo_q, mhi_q, len_q;
  logic [AW-1:0] idx_q, free_q;

  // control and running state
  logic [iut_pkg::TABLE_SLOTS-1:0] valid_q;
  logic [iut_pkg::CNT_BITS-1:0]    cnt_q;
  logic [iut_pkg::COV_BITS-1:0]    cov_q;
  logic [iut_pkg::TALLY_BITS-1:0]  tally_q;
  iut_pkg::status_e                status_q;
  logic chk_q, any_q, hit_q, found_q, sub_q, add_q;

  logic [iut_pkg::ENTRY_BITS-1:0] rdata;
  logic [VB-1:0] rd_lo, rd_hi;
  logic          ovl, vld, ins_ok, merge, free_after, full, commit;

  iut_ram #(
    .WIDTH(iut_pkg::ENTRY_BITS),
    .DEPTH(iut_pkg::TABLE_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (commit),
    .waddr_i(free_q),
    .wdata_i({mlo_q, mhi_q}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  assign rd_lo      = rdata[2*VB-1:VB];
  assign rd_hi      = rdata[VB-1:0];
  assign vld        = valid_q[idx_q];
  assign ovl        = (rd_lo <= hi_q) && (lo_q <= rd_hi);
  assign ins_ok     = (op_q == iut_pkg::OP_INSERT) && !bad_q;
  assign merge      = chk_q && vld && ovl && ins_ok;
  assign free_after = !vld || (ovl && ins_ok);
  assign full       = !any_q && (cnt_q == iut_pkg::CNT_BITS'(iut_pkg::TABLE_SLOTS));
  assign commit     = cmd_i.finish && ins_ok && !full;

  // payload
  always_ff @(posedge clk_i) begin
    idx_q <= cmd_i.rd_addr;
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      lo_q  <= low_value_i;
      hi_q  <= (opcode_i == iut_pkg::OP_QUERY) ? low_value_i : high_value_i;
      bad_q <= (opcode_i == iut_pkg::OP_INSERT) && (low_value_i > high_value_i);
      mlo_q <= low_value_i;
      mhi_q <= high_value_i;
    end
    if (merge) begin
      if (rd_lo < mlo_q) begin
        mlo_q <= rd_lo;
      end
      if (rd_hi > mhi_q) begin
        mhi_q <= rd_hi;
      end
      len_q <= rd_hi - rd_lo;
    end
    if (commit) begin
      len_q <= mhi_q - mlo_q;
    end
    if (chk_q && !found_q && free_after) begin
      free_q <= idx_q;
    end
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      cov_q    <= '0;
      tally_q  <= '0;
      status_q <= iut_pkg::ST_OK;
      chk_q    <= 1'b0;
      any_q    <= 1'b0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      sub_q    <= 1'b0;
      add_q    <= 1'b0;
    end else begin
      chk_q <= cmd_i.rd_en;
      sub_q <= merge;
      add_q <= commit;
      if (cmd_i.load) begin
        any_q   <= 1'b0;
        hit_q   <= 1'b0;
        found_q <= 1'b0;
      end
      if (chk_q && vld && ovl) begin
        if (op_q == iut_pkg::OP_QUERY) begin
          hit_q <= 1'b1;
        end
      end
      if (merge) begin
        any_q          <= 1'b1;
        valid_q[idx_q] <= 1'b0;
        cnt_q          <= cnt_q - iut_pkg::CNT_BITS'(1);
      end
      if (chk_q && !found_q && free_after) begin
        found_q <= 1'b1;
      end
      if (sub_q) begin
        cov_q <= cov_q - {1'b0, len_q} - iut_pkg::COV_BITS'(1);
      end else if (add_q) begin
        cov_q <= cov_q + {1'b0, len_q} + iut_pkg::COV_BITS'(1);
      end
      if (cmd_i.finish) begin
        priority if (op_q == iut_pkg::OP_QUERY) begin
          status_q <= iut_pkg::ST_OK;
          if (hit_q && (tally_q != {iut_pkg::TALLY_BITS{1'b1}})) begin
            tally_q <= tally_q + iut_pkg::TALLY_BITS'(1);
          end
        end else if (bad_q) begin
          status_q <= iut_pkg::ST_BAD;
        end else if (full) begin
          status_q <= iut_pkg::ST_FULL;
        end else begin
          status_q        <= iut_pkg::ST_OK;
          valid_q[free_q] <= 1'b1;
          cnt_q           <= cnt_q + iut_pkg::CNT_BITS'(1);
        end
      end
    end
  end

  assign status_o        = status_q;
  assign hit_o           = hit_q;
  assign covered_total_o = cov_q;
  assign slots_in_use_o  = cnt_q;
  assign hits_so_far_o   = tally_q;

  `IUT_ASSERT(a_count_matches_valid, cnt_q == iut_pkg::CNT_BITS'($countones(valid_q)))
  `IUT_ASSERT(a_add_sub_exclusive, !(add_q && sub_q))
  `IUT_ASSERT_MSG(a_commit_has_free, commit |-> found_q, "write without a free slot")

endmodule

`default_nettype wire

FILE: hw/rtl/interval_union_table_unit.sv
// top level of the interval union table: sequencer plus datapath
// depends on iut_pkg, iut_ctrl, iut_dp and iut_ram
`timescale 1ns / 1ps
`default_nettype none

// An item is taken at a clock edge where start_i is high and busy_o is low.
// Each insert or query reads all TABLE_SLOTS table entries, one per cycle
// through the single read port of the slot memory, then passes through the
// drain, finish and settle states for the last compare, the merge write-back
// and the counter updates before done_o rises. The word is taken at the edge
// that ends the cycle in which done_o is high; busy_o drops at that edge,
// so the next item can be taken in the cycle after that edge.
// The result ports are valid only while done_o is high; the receiver cannot
// stall them and must capture the word in that cycle.

module interval_union_table_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            opcode_i,
  input  wire logic [iut_pkg::VALUE_BITS-1:0]  low_value_i,
  input  wire logic [iut_pkg::VALUE_BITS-1:0]  high_value_i,
  output logic                                 done_o,
  output logic      [1:0]                      status_o,
  output logic                                 hit_o,
  output logic      [iut_pkg::COV_BITS-1:0]    covered_total_o,
  output logic      [iut_pkg::CNT_BITS-1:0]    slots_in_use_o,
  output logic      [iut_pkg::TALLY_BITS-1:0]  hits_so_far_o
);

  iut_pkg::cmd_t cmd;

  iut_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  iut_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .low_value_i    (low_value_i),
    .high_value_i   (high_value_i),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .covered_total_o(covered_total_o),
    .slots_in_use_o (slots_in_use_o),
    .hits_so_far_o  (hits_so_far_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for interval_union_table_unit: directed and random words
// checked against an in-bench interval table predictor; depends on iut_pkg
`timescale 1ns / 1ps

module tb_top;

  typedef logic [iut_pkg::VALUE_BITS-1:0] value_t;

  typedef struct {
    iut_pkg::status_e               status;
    logic                           hit;
    logic [iut_pkg::COV_BITS-1:0]   covered;
    logic [iut_pkg::CNT_BITS-1:0]   slots;
    logic [iut_pkg::TALLY_BITS-1:0] hits;
  } outcome_t;

  localparam value_t      TOP_VALUE   = {iut_pkg::VALUE_BITS{1'b1}};
  localparam int unsigned WIN_SPAN    = 4096;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 40;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start_i;
  logic                           busy_o;
  logic                           opcode_i;
  value_t                         low_value_i;
  value_t                         high_value_i;
  logic                           done_o;
  logic [1:0]                     status_o;
  logic                           hit_o;
  logic [iut_pkg::COV_BITS-1:0]   covered_total_o;
  logic [iut_pkg::CNT_BITS-1:0]   slots_in_use_o;
  logic [iut_pkg::TALLY_BITS-1:0] hits_so_far_o;

  // predictor copy of the table
  value_t                         iv_lo    [iut_pkg::TABLE_SLOTS];
  value_t                         iv_hi    [iut_pkg::TABLE_SLOTS];
  logic                           iv_valid [iut_pkg::TABLE_SLOTS];
  logic [iut_pkg::CNT_BITS-1:0]   iv_count;
  logic [iut_pkg::COV_BITS-1:0]   iv_covered;
  logic [iut_pkg::TALLY_BITS-1:0] iv_hits;

  outcome_t    pending_words[$];
  int unsigned send_idle_pct;
  value_t      win_base;
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_inserts;
  int unsigned n_queries;
  int unsigned n_full;
  int unsigned n_bad;
  int unsigned stall_cycles;

  interval_union_table_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .low_value_i     (low_value_i),
    .high_value_i    (high_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .hit_o           (hit_o),
    .covered_total_o (covered_total_o),
    .slots_in_use_o  (slots_in_use_o),
    .hits_so_far_o   (hits_so_far_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic spans_meet(value_t alo, value_t ahi, value_t blo, value_t bhi);
    return (alo <= bhi) && (blo <= ahi);
  endfunction

  function automatic logic value_covered(value_t v);
    for (int i = 0; i < iut_pkg::TABLE_SLOTS; i++) begin
      if (iv_valid[i] && iv_lo[i] <= v && v <= iv_hi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic value_t add_clamped(value_t a, int unsigned d);
    logic [iut_pkg::VALUE_BITS:0] sum;
    sum = {1'b0, a} + d;
    return sum[iut_pkg::VALUE_BITS] ? TOP_VALUE : sum[iut_pkg::VALUE_BITS-1:0];
  endfunction

  function automatic value_t rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[iut_pkg::VALUE_BITS-1:0];
  endfunction

  function automatic int pick_stored_slot();
    int start_idx;
    int idx;
    start_idx = $urandom_range(0, iut_pkg::TABLE_SLOTS - 1);
    for (int k = 0; k < iut_pkg::TABLE_SLOTS; k++) begin
      idx = (start_idx + k) % iut_pkg::TABLE_SLOTS;
      if (iv_valid[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_word(logic op, value_t lo, value_t hi);
    outcome_t res;
    logic     any_meet;
    int       free_idx;
    res.status = iut_pkg::ST_OK;
    res.hit    = 1'b0;
    if (op == iut_pkg::OP_INSERT) begin
      n_inserts++;
      any_meet = 1'b0;
      for (int i = 0; i < iut_pkg::TABLE_SLOTS; i++) begin
        if (iv_valid[i] && spans_meet(lo, hi, iv_lo[i], iv_hi[i])) any_meet = 1'b1;
      end
      if (lo > hi) begin
        res.status = iut_pkg::ST_BAD;
        n_bad++;
      end else if (!any_meet && iv_count >= iut_pkg::TABLE_SLOTS) begin
        res.status = iut_pkg::ST_FULL;
        n_full++;
      end else begin
        for (int i = 0; i < iut_pkg::TABLE_SLOTS; i++) begin
          if (iv_valid[i] && spans_meet(lo, hi, iv_lo[i], iv_hi[i])) begin
            if (iv_lo[i] < lo) lo = iv_lo[i];
            if (iv_hi[i] > hi) hi = iv_hi[i];
            iv_covered = iv_covered - ({1'b0, iv_hi[i]} - {1'b0, iv_lo[i]} + 1'b1);
            iv_valid[i] = 1'b0;
            iv_count--;
          end
        end
        free_idx = -1;
        for (int i = iut_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
          if (!iv_valid[i]) free_idx = i;
        end
        iv_lo[free_idx]    = lo;
        iv_hi[free_idx]    = hi;
        iv_valid[free_idx] = 1'b1;
        iv_count++;
        iv_covered = iv_covered + ({1'b0, hi} - {1'b0, lo} + 1'b1);
      end
    end else begin
      n_queries++;
      res.hit = value_covered(lo);
      if (res.hit && iv_hits != {iut_pkg::TALLY_BITS{1'b1}}) iv_hits++;
    end
    res.covered = iv_covered;
    res.slots   = iv_count;
    res.hits    = iv_hits;
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(logic op, value_t lo, value_t hi);
    logic idle;
    opcode_i     <= op;
    low_value_i  <= lo;
    high_value_i <= hi;
    forever begin
      idle = ($urandom_range(0, 99) < send_idle_pct);
      start_i <= !idle;
      @(posedge clk_i);
      if (!idle && !busy_o) break;
      @(negedge clk_i);
    end
    pending_words.push_back(apply_word(op, lo, hi));
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    n_errors++;
    if (n_errors <= PRINT_LIMIT)
      $display("mismatch in word %0d: %s got 0x%0h expected 0x%0h", n_results, field, got, want);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 64'd1, 64'd0);
      end else begin
        want = pending_words.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (covered_total_o !== want.covered)
          report_mismatch("covered_total", covered_total_o, want.covered);
        if (slots_in_use_o !== want.slots)
          report_mismatch("slots_in_use", slots_in_use_o, want.slots);
        if (hits_so_far_o !== want.hits)
          report_mismatch("hits_so_far", hits_so_far_o, want.hits);
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_table();
    send_word(iut_pkg::OP_QUERY, '0, '0);
    send_word(iut_pkg::OP_QUERY, TOP_VALUE, '0);
    send_word(iut_pkg::OP_INSERT, value_t'(5), value_t'(4));
    send_word(iut_pkg::OP_INSERT, TOP_VALUE, '0);
  endtask

  task automatic test_adjacent_and_merge();
    send_word(iut_pkg::OP_INSERT, value_t'(10), value_t'(19));
    send_word(iut_pkg::OP_INSERT, value_t'(20), value_t'(29));
    send_word(iut_pkg::OP_INSERT, value_t'(31), value_t'(31));
    send_word(iut_pkg::OP_QUERY, value_t'(19), TOP_VALUE);
    send_word(iut_pkg::OP_QUERY, value_t'(20), '0);
    send_word(iut_pkg::OP_QUERY, value_t'(30), '0);
    send_word(iut_pkg::OP_QUERY, value_t'(31), '0);
    send_word(iut_pkg::OP_INSERT, value_t'(15), value_t'(25));
    send_word(iut_pkg::OP_INSERT, value_t'(29), value_t'(31));
    send_word(iut_pkg::OP_INSERT, value_t'(10), value_t'(31));
    send_word(iut_pkg::OP_QUERY, value_t'(9), '0);
    send_word(iut_pkg::OP_QUERY, value_t'(32), '0);
    send_word(iut_pkg::OP_INSERT, '0, '0);
    send_word(iut_pkg::OP_INSERT, TOP_VALUE, TOP_VALUE);
    send_word(iut_pkg::OP_QUERY, TOP_VALUE, '0);
    send_word(iut_pkg::OP_QUERY, '0, TOP_VALUE);
    send_word(iut_pkg::OP_INSERT, value_t'(1), value_t'(9));
  endtask

  task automatic run_random_phase(int unsigned n_words, int unsigned idle_pct, value_t base);
    int unsigned sel;
    int          idx;
    logic        op;
    value_t      lo;
    value_t      hi;
    value_t      tmp;
    send_idle_pct = idle_pct;
    // fold the previous window into one interval so slots come free
    send_word(iut_pkg::OP_INSERT, win_base, add_clamped(win_base, WIN_SPAN + 400));
    win_base = base;
    for (int n = 0; n < n_words; n++) begin
      sel = $urandom_range(0, 99);
      op  = iut_pkg::OP_INSERT;
      lo  = add_clamped(win_base, $urandom_range(0, WIN_SPAN));
      hi  = lo;
      idx = pick_stored_slot();
      if (sel < 8) begin
        op  = 1'($urandom_range(0, 1));
        lo  = rand_value();
        tmp = rand_value();
        hi  = (tmp >= lo) ? add_clamped(lo, $urandom_range(0, 15)) : tmp;
      end else if (sel < 52) begin
        case ($urandom_range(0, 19))
          0:       hi = add_clamped(lo, $urandom_range(0, WIN_SPAN / 2));
          1, 2:    hi = add_clamped(lo, $urandom_range(0, 300));
          3:       begin
            hi = lo;
            lo = add_clamped(lo, $urandom_range(1, 20));
          end
          default: hi = add_clamped(lo, $urandom_range(0, 8));
        endcase
      end else if (sel < 62 && idx >= 0) begin
        if (iv_hi[idx] != TOP_VALUE && ($urandom_range(0, 1) || iv_lo[idx] == '0)) begin
          lo = iv_hi[idx] + 1'b1;
          hi = add_clamped(lo, $urandom_range(0, 6));
        end else begin
          hi = iv_lo[idx] - 1'b1;
          lo = (hi > 6) ? hi - $urandom_range(0, 6) : '0;
        end
      end else begin
        op = iut_pkg::OP_QUERY;
        hi = rand_value();
        if (idx >= 0 && $urandom_range(0, 1)) begin
          case ($urandom_range(0, 3))
            0: lo = iv_lo[idx] - 1'b1;
            1: lo = iv_lo[idx];
            2: lo = iv_hi[idx];
            default: lo = iv_hi[idx] + 1'b1;
          endcase
        end
      end
      send_word(op, lo, hi);
    end
  endtask

  task automatic test_full_table();
    value_t region;
    value_t probe;
    int     k;
    region = value_t'(1) << (iut_pkg::VALUE_BITS - 1);
    k = 0;
    while (iv_count < iut_pkg::TABLE_SLOTS && k < 4 * iut_pkg::TABLE_SLOTS) begin
      send_word(iut_pkg::OP_INSERT, region + 16 * k, region + 16 * k + 3);
      k++;
    end
    probe = region + 8;
    while (value_covered(probe)) probe = probe + 16;
    send_word(iut_pkg::OP_INSERT, probe, probe + 1);
    send_word(iut_pkg::OP_INSERT, probe + 1, probe);
    send_word(iut_pkg::OP_QUERY, probe, '0);
    send_word(iut_pkg::OP_INSERT, region + 2, region + 17);
    send_word(iut_pkg::OP_INSERT, probe, probe + 1);
    send_word(iut_pkg::OP_INSERT, probe + 64, probe + 64);
  endtask

  task automatic test_whole_range();
    send_word(iut_pkg::OP_INSERT, '0, TOP_VALUE);
    send_word(iut_pkg::OP_QUERY, '0, '0);
    send_word(iut_pkg::OP_QUERY, TOP_VALUE, '0);
    send_word(iut_pkg::OP_QUERY, rand_value(), '0);
    send_word(iut_pkg::OP_INSERT, value_t'(7), value_t'(9));
  endtask

  initial begin
    value_t mid_base;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    opcode_i      = iut_pkg::OP_INSERT;
    low_value_i   = '0;
    high_value_i  = '0;
    send_idle_pct = 14;
    win_base      = '0;
    n_errors      = 0;
    n_results     = 0;
    n_inserts     = 0;
    n_queries     = 0;
    n_full        = 0;
    n_bad         = 0;
    stall_cycles  = 0;
    iv_count      = '0;
    iv_covered    = '0;
    iv_hits       = '0;
    for (int i = 0; i < iut_pkg::TABLE_SLOTS; i++) begin
      iv_lo[i]    = '0;
      iv_hi[i]    = '0;
      iv_valid[i] = 1'b0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_adjacent_and_merge();
    mid_base = rand_value() % (TOP_VALUE - 3 * WIN_SPAN);
    run_random_phase(290, 14, value_t'(5000));
    run_random_phase(290, 76, mid_base);
    run_random_phase(290, 0, TOP_VALUE - WIN_SPAN - 400);
    test_full_table();
    test_whole_range();

    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("ran %0d inserts (%0d dropped on a full table, %0d dropped as start above end)",
             n_inserts, n_full, n_bad);
    $display("and %0d queries with %0d hits; %0d words checked, %0d mismatches",
             n_queries, iv_hits, n_results, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/iut_pkg.sv
hw/rtl/iut_ram.sv
hw/rtl/iut_ctrl.sv
hw/rtl/iut_dp.sv
hw/rtl/interval_union_table_unit.sv
tb/tb_top.sv
